[src/csdd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the chip slicer and DPLL demodulator.
package csdd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FILT_W = 18;
	localparam int ALU_W = 20;
	localparam int ALU_RES_W = 22;
	localparam int PHASE_W = 32;
	localparam int STEP_W = 31;
	localparam int FLOOR_W = 12;
	localparam int TOTAL_W = 32;
	localparam int COUNT_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_STEPS = TOTAL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(858993459);
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(8);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_FLOOR = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		SH_1,
		SH_2,
		SH_6,
		SH_10
	} shamt_t;

	typedef struct packed {
		logic signed [ALU_W-1:0] a;
		logic signed [ALU_W-1:0] b;
		logic signed [ALU_W-1:0] c;
		logic inner_add;
		logic outer_sub;
		shamt_t sh;
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LP,
		S_PH,
		S_PL,
		S_CEN,
		S_ENV,
		S_SLICE,
		S_PULL,
		S_DIV,
		S_OUT
	} state_t;

endpackage

[src/csdd_alu.sv]
`timescale 1ns / 1ps
// Shared filter unit computing a plus or minus an arithmetic shift of b plus or minus c.
module csdd_alu import csdd_pkg::*; (
	input alu_op_t op,
	output logic signed [ALU_RES_W-1:0] res
);

	logic signed [ALU_RES_W-1:0] inner;
	logic signed [ALU_RES_W-1:0] shifted;
	logic signed [ALU_RES_W-1:0] a_ext;

	always_comb begin
		a_ext = ALU_RES_W'(op.a);
		if (op.inner_add) begin
			inner = ALU_RES_W'(op.b) + ALU_RES_W'(op.c);
		end else begin
			inner = ALU_RES_W'(op.b) - ALU_RES_W'(op.c);
		end
		case (op.sh)
			SH_1: shifted = inner >>> 1;
			SH_2: shifted = inner >>> 2;
			SH_6: shifted = inner >>> 6;
			SH_10: shifted = inner >>> 10;
			default: shifted = inner;
		endcase
		if (op.outer_sub) begin
			res = a_ext - shifted;
		end else begin
			res = a_ext + shifted;
		end
	end

endmodule

[src/csdd_div.sv]
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module csdd_div import csdd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [TOTAL_W-1:0] dividend,
	input logic [COUNT_W-1:0] divisor,
	output logic busy,
	output logic done,
	output logic signed [TOTAL_W:0] quotient
);

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic neg_q;
	logic [TOTAL_W-1:0] quo_q;
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] dvs_q;
	logic [COUNT_W:0] shifted;
	logic signed [COUNT_W+1:0] trial;
	logic [TOTAL_W:0] mag;

	always_comb begin
		shifted = {rem_q, quo_q[TOTAL_W-1]};
		trial = $signed({1'b0, shifted}) - $signed({2'b00, dvs_q});
		mag = dividend[TOTAL_W-1] ? -(TOTAL_W+1)'(dividend) : (TOTAL_W+1)'(dividend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[TOTAL_W-1];
			quo_q <= mag[TOTAL_W-1:0];
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[COUNT_W+1]) begin
				rem_q <= trial[COUNT_W-1:0];
				quo_q <= {quo_q[TOTAL_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[COUNT_W-1:0];
				quo_q <= {quo_q[TOTAL_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

[src/chip_slicer_dpll_demod.sv]
`timescale 1ns / 1ps
// Top level: slicer filters, phase accumulator, cell averager and sequencer.
// A sample with no cell completion passes the filter and phase states, then idles.
// A sample that completes a cell also starts the divider: 32 steps of one quotient bit
// each, then the result is loaded once the output register is free.
// A result waits in the output register; a newer one stalls until that register is free.
// Reset clears all filter, phase and cell state and loads the register defaults.
module chip_slicer_dpll_demod import csdd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [SAMPLE_W-1:0] sample,
	output logic out_valid,
	input logic out_ready,
	output logic chip,
	output logic signed [SAMPLE_W-1:0] cell_mean,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [STEP_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [STEP_W-1:0] step_q;
	logic [FLOOR_W-1:0] floor_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic signed [FILT_W-1:0] lp_q, ph_q, pl_q, env_q;
	logic signed [ALU_W-1:0] cen_q;
	logic signed [FILT_W:0] mid_q;
	logic slicer_q, prev_q, emit_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TOTAL_W-1:0] total_q;
	logic [COUNT_W-1:0] count_q;
	logic out_valid_q, chip_q;
	logic signed [SAMPLE_W-1:0] avg_q;

	alu_op_t alu_op;
	logic signed [ALU_RES_W-1:0] alu_res;
	logic div_start, div_busy, div_done;
	logic signed [TOTAL_W:0] quotient;
	logic in_fire, out_load;
	logic signed [FILT_W:0] pk_sum;
	logic signed [ALU_W-1:0] mag, th_env, th_sel;
	logic [PHASE_W-1:0] phase_add;
	logic [PHASE_W-1:0] phase_pull;

	csdd_alu u_alu (
		.op(alu_op),
		.res(alu_res)
	);

	csdd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend($signed(total_q)),
		.divisor(count_q),
		.busy(div_busy),
		.done(div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		alu_op = '{a: '0, b: '0, c: '0, inner_add: 1'b0, outer_sub: 1'b0, sh: SH_2};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_LP;
				end
			end
			S_LP: begin
				alu_op.a = ALU_W'(lp_q);
				alu_op.b = ALU_W'(samp_q);
				alu_op.c = ALU_W'(lp_q);
				state_d = S_PH;
			end
			S_PH: begin
				if (lp_q > ph_q) begin
					alu_op.a = ALU_W'(ph_q);
					alu_op.b = ALU_W'(lp_q);
					alu_op.c = ALU_W'(ph_q);
				end else begin
					alu_op.a = ALU_W'(ph_q);
					alu_op.b = ALU_W'(ph_q);
					alu_op.c = ALU_W'(pl_q);
					alu_op.outer_sub = 1'b1;
					alu_op.sh = SH_10;
				end
				state_d = S_PL;
			end
			S_PL: begin
				if (lp_q < pl_q) begin
					alu_op.a = ALU_W'(pl_q);
					alu_op.b = ALU_W'(lp_q);
					alu_op.c = ALU_W'(pl_q);
				end else begin
					alu_op.a = ALU_W'(pl_q);
					alu_op.b = ALU_W'(ph_q);
					alu_op.c = ALU_W'(pl_q);
					alu_op.sh = SH_10;
				end
				state_d = S_CEN;
			end
			S_CEN: begin
				alu_op.a = ALU_W'(lp_q);
				alu_op.b = ALU_W'(ph_q);
				alu_op.c = ALU_W'(pl_q);
				alu_op.inner_add = 1'b1;
				alu_op.outer_sub = 1'b1;
				alu_op.sh = SH_1;
				state_d = S_ENV;
			end
			S_ENV: begin
				alu_op.a = ALU_W'(env_q);
				alu_op.b = mag;
				alu_op.c = ALU_W'(env_q);
				alu_op.sh = SH_6;
				state_d = S_SLICE;
			end
			S_SLICE: begin
				state_d = S_PULL;
			end
			S_PULL: begin
				if (emit_q) begin
					div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_fire = in_valid && in_ready;
		pk_sum = (FILT_W+1)'(ph_q) + (FILT_W+1)'(pl_q);
		mag = cen_q[ALU_W-1] ? -cen_q : cen_q;
		th_env = ALU_W'(env_q >>> 2);
		th_sel = (th_env < $signed({{(ALU_W-FLOOR_W){1'b0}}, floor_q})) ?
			$signed({{(ALU_W-FLOOR_W){1'b0}}, floor_q}) : th_env;
		phase_add = phase_q + {1'b0, step_q};
		phase_pull = phase_q - PHASE_W'($signed(phase_q) >>> 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			floor_q <= FLOOR_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PHASE_STEP) begin
				step_q <= cfg_data;
			end else if (cfg_index == REG_SLICE_FLOOR) begin
				floor_q <= cfg_data[FLOOR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			ph_q <= '0;
			pl_q <= '0;
			env_q <= '0;
			cen_q <= '0;
			mid_q <= '0;
			slicer_q <= 1'b0;
			prev_q <= 1'b0;
			emit_q <= 1'b0;
			phase_q <= '0;
			total_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				total_q <= total_q + TOTAL_W'(sample);
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
			case (state_q)
				S_LP: lp_q <= alu_res[FILT_W-1:0];
				S_PH: ph_q <= alu_res[FILT_W-1:0];
				S_PL: pl_q <= alu_res[FILT_W-1:0];
				S_CEN: begin
					cen_q <= alu_res[ALU_W-1:0];
					mid_q <= (pk_sum + $signed((FILT_W+1)'(pk_sum[FILT_W]))) >>> 1;
				end
				S_ENV: env_q <= alu_res[FILT_W-1:0];
				S_SLICE: begin
					if (cen_q > th_sel) begin
						slicer_q <= 1'b0;
					end else if (cen_q < -th_sel) begin
						slicer_q <= 1'b1;
					end
					phase_q <= phase_add;
					emit_q <= phase_q[PHASE_W-1] && !phase_add[PHASE_W-1];
				end
				S_PULL: begin
					if (slicer_q != prev_q) begin
						phase_q <= phase_pull;
						prev_q <= slicer_q;
					end
					if (emit_q) begin
						total_q <= '0;
						count_q <= '0;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			samp_q <= sample;
		end
		if (out_load) begin
			chip_q <= quotient < (TOTAL_W+1)'(mid_q);
			avg_q <= quotient[SAMPLE_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign chip = chip_q;
	assign cell_mean = avg_q;
	assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
	a_idle_not_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_busy)
		else $error("Input request taken while the divider is running.");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("Divider finished outside of the divide state.");

	a_cell_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> count_q == '0 && total_q == '0)
		else $error("Cell accumulators not cleared while dividing.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && state_q == S_LP)
		else $error("Sequencer did not start on an accepted request.");
`endif

endmodule

[tb/chip_slicer_dpll_demod_checker.sv]
`timescale 1ns / 1ps
// Checker for the chip demodulator: predicts cell results from the sample requests and compares.
module chip_slicer_dpll_demod_checker import csdd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic signed [SAMPLE_W-1:0] sample,
	input logic out_valid,
	input logic out_ready,
	input logic chip,
	input logic signed [SAMPLE_W-1:0] cell_mean,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [STEP_W-1:0] cfg_data,
	output int fail_count,
	output int pending,
	output int cells_predicted
);

	typedef struct {
		logic chip;
		logic signed [SAMPLE_W-1:0] avg;
	} cell_result_t;

	cell_result_t cells_due[$];
	cell_result_t want;

	logic [STEP_W-1:0] step_q;
	logic [FLOOR_W-1:0] floor_q;
	logic signed [FILT_W-1:0] lowpass_q;
	logic signed [FILT_W-1:0] peak_hi_q;
	logic signed [FILT_W-1:0] peak_lo_q;
	logic signed [FILT_W-1:0] envelope_q;
	logic slice_q;
	logic slice_prev_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TOTAL_W-1:0] total_q;
	logic [COUNT_W-1:0] count_q;
	int mismatches;
	int cells_made;

	task automatic demod_sample(input logic signed [SAMPLE_W-1:0] smp);
		longint s;
		longint v;
		longint centred;
		longint mag;
		longint thresh;
		longint quot;
		longint mid;
		logic phase_msb;
		logic signed [PHASE_W-1:0] pull;
		cell_result_t res;
		s = smp;
		v = lowpass_q + ((s - lowpass_q) >>> 2);
		lowpass_q = v[FILT_W-1:0];
		if (lowpass_q > peak_hi_q)
			v = peak_hi_q + ((longint'(lowpass_q) - peak_hi_q) >>> 2);
		else
			v = peak_hi_q - ((longint'(peak_hi_q) - peak_lo_q) >>> 10);
		peak_hi_q = v[FILT_W-1:0];
		if (lowpass_q < peak_lo_q)
			v = peak_lo_q + ((longint'(lowpass_q) - peak_lo_q) >>> 2);
		else
			v = peak_lo_q + ((longint'(peak_hi_q) - peak_lo_q) >>> 10);
		peak_lo_q = v[FILT_W-1:0];

		centred = longint'(lowpass_q) - ((longint'(peak_hi_q) + peak_lo_q) >>> 1);
		mag = (centred < 0) ? -centred : centred;
		v = envelope_q + ((mag - envelope_q) >>> 6);
		envelope_q = v[FILT_W-1:0];
		thresh = longint'(envelope_q) >>> 2;
		if (thresh < longint'(floor_q))
			thresh = longint'(floor_q);
		if (centred > thresh)
			slice_q = 1'b0;
		else if (centred < -thresh)
			slice_q = 1'b1;

		total_q = total_q + TOTAL_W'(s);
		if (count_q != COUNT_MAX)
			count_q = count_q + COUNT_W'(1);

		phase_msb = phase_q[PHASE_W-1];
		phase_q = phase_q + {1'b0, step_q};
		if (phase_msb && !phase_q[PHASE_W-1]) begin
			quot = longint'($signed(total_q)) / ((count_q == 0) ? 1 : longint'(count_q));
			mid = (longint'(peak_hi_q) + peak_lo_q) / 2;
			res.chip = (quot >= mid) ? 1'b0 : 1'b1;
			res.avg = quot[SAMPLE_W-1:0];
			cells_due.push_back(res);
			cells_made++;
			total_q = '0;
			count_q = '0;
		end

		// A slicer transition pulls the phase a quarter of the way toward zero.
		if (slice_q != slice_prev_q) begin
			pull = $signed(phase_q) >>> 2;
			phase_q = phase_q - pull;
			slice_prev_q = slice_q;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			step_q = STEP_RESET;
			floor_q = FLOOR_RESET;
			lowpass_q = '0;
			peak_hi_q = '0;
			peak_lo_q = '0;
			envelope_q = '0;
			slice_q = 1'b0;
			slice_prev_q = 1'b0;
			phase_q = '0;
			total_q = '0;
			count_q = '0;
			cells_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PHASE_STEP: step_q = cfg_data;
					REG_SLICE_FLOOR: floor_q = cfg_data[FLOOR_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (cells_due.size() == 0) begin
					$error("result with no request outstanding: chip %0d, cell_mean %0d",
						chip, cell_mean);
					mismatches++;
				end else begin
					want = cells_due.pop_front();
					if (chip !== want.chip) begin
						$error("chip mismatch: expected %0d, got %0d", want.chip, chip);
						mismatches++;
					end
					if (cell_mean !== want.avg) begin
						$error("cell_mean mismatch: expected %0d, got %0d", want.avg,
							cell_mean);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				demod_sample(sample);
		end
		fail_count <= mismatches;
		pending <= cells_due.size();
		cells_predicted <= cells_made;
	end

endmodule

[tb/chip_slicer_dpll_demod_tb.sv]
`timescale 1ns / 1ps
// Testbench top: drives sample and register requests into the chip demodulator and gives the verdict.
module chip_slicer_dpll_demod_tb;
	import csdd_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 140;
	localparam int HEAVY_IDLE_PCT = 58;
	localparam int LIGHT_IDLE_PCT = 6;
	localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(16843010);
	localparam logic [STEP_W-1:0] STEP_MAX = '1;
	localparam logic [FLOOR_W-1:0] FLOOR_MAX = '1;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef enum {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idling_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic chip;
	logic signed [SAMPLE_W-1:0] cell_mean;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PHASE_STEP;
	logic [STEP_W-1:0] cfg_data = '0;
	int fail_count;
	int pending;
	int cells_predicted;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_left;

	chip_slicer_dpll_demod dut (.*);

	chip_slicer_dpll_demod_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [STEP_W-1:0] step, input logic [FLOOR_W-1:0] floor_sel);
		logic [STEP_W-1:0] floor_word;
		drain();
		write_reg(REG_PHASE_STEP, step);
		floor_word = STEP_W'($urandom);
		floor_word[FLOOR_W-1:0] = floor_sel;
		write_reg(REG_SLICE_FLOOR, floor_word);
		write_reg($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, STEP_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Two-level chip bursts; well-formed bursts hold each level for about one cell.
	task automatic play_chips(input logic [STEP_W-1:0] step, input bit well_formed);
		int spc;
		int amp;
		int spread;
		int offset;
		int level;
		int len;
		int v;
		spc = int'(64'h1_0000_0000 / step);
		amp = $urandom_range(30000, 100);
		spread = amp / 8;
		offset = int'($urandom_range(4000)) - 2000;
		repeat ($urandom_range(6, 2)) begin
			level = offset + ($urandom_range(1) ? amp : -amp);
			if (well_formed)
				len = spc - 1 + int'($urandom_range(2));
			else
				len = $urandom_range(3 * spc, 1);
			if (len < 1)
				len = 1;
			repeat (len) begin
				if (items_left == 0)
					return;
				v = level - spread + int'($urandom_range(2 * spread));
				if (v > SAMPLE_MAX)
					v = SAMPLE_MAX;
				else if (v < SAMPLE_MIN)
					v = SAMPLE_MIN;
				send_sample(SAMPLE_W'(v));
				items_left--;
			end
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int p;
		int kind;
		int cells_before;
		logic [STEP_W-1:0] step;
		logic [FLOOR_W-1:0] floor_sel;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(STEP_RESET, FLOOR_RESET);

		repeat (4) send_sample(SAMPLE_MAX);
		repeat (4) send_sample(SAMPLE_MIN);
		repeat (3) send_sample(SAMPLE_MAX);
		repeat (3) send_sample(SAMPLE_MIN);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);
		repeat (4) send_sample(16'sd0);

		configure(STEP_MAX, FLOOR_RESET);
		cells_before = cells_predicted;
		while (cells_predicted == cells_before)
			send_sample(SAMPLE_MAX);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					step = STEP_MIN;
					floor_sel = '0;
				end
				1: begin
					step = STEP_MAX;
					floor_sel = FLOOR_MAX;
				end
				2: begin
					step = STEP_RESET;
					floor_sel = FLOOR_RESET;
				end
				default: begin
					step = STEP_W'($urandom_range(STEP_MAX, STEP_MIN));
					floor_sel = $urandom_range(1) ? FLOOR_W'($urandom_range(255))
						: FLOOR_W'($urandom);
				end
			endcase
			configure(step, floor_sel);
			case (idling_t'(p % 4))
				IDLE_NONE: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				IDLE_SENDER: begin
					send_idle_pct = HEAVY_IDLE_PCT;
					recv_stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					send_idle_pct = 0;
					recv_stall_pct = HEAVY_IDLE_PCT;
				end
				IDLE_BOTH: begin
					send_idle_pct = LIGHT_IDLE_PCT;
					recv_stall_pct = LIGHT_IDLE_PCT;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			items_left = PHASE_ITEMS;
			while (items_left > 0) begin
				kind = $urandom_range(99);
				if (kind < 70) begin
					play_chips(step, 1'b1);
				end else if (kind < 85) begin
					play_chips(step, 1'b0);
				end else if (kind < 95) begin
					send_sample(SAMPLE_W'($urandom));
					items_left--;
				end else begin
					send_sample($urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN);
					items_left--;
				end
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
src/csdd_pkg.sv
src/csdd_alu.sv
src/csdd_div.sv
src/chip_slicer_dpll_demod.sv
tb/chip_slicer_dpll_demod_checker.sv
tb/chip_slicer_dpll_demod_tb.sv
